### rtl/dkh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkh_pkg
// Shared types and constants of the k-mer histogram unit.
// ----------------------------------------------------------------------------
package dkh_pkg;

	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	localparam logic MODE_BASE  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_COUNT   = 1'b1;

	// back part states
	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_QRD,
		BK_WREAD,
		BK_WUPD,
		BK_OUT
	} bk_state_t;

	// decoded base: valid flag and 2-bit code
	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_dec_t;

	function automatic base_dec_t decode_base(input logic [7:0] ch);
		base_dec_t d;
		d.ok = 1'b1;
		d.code = 2'd0;
		unique case (ch)
			CHAR_A: d.code = 2'd0;
			CHAR_C: d.code = 2'd1;
			CHAR_G: d.code = 2'd2;
			CHAR_T: d.code = 2'd3;
			default: d.ok = 1'b0;
		endcase
		return d;
	endfunction

endpackage

### rtl/dkh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkh_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dkh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/dkh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkh_front
// Accepts items, buffers read bases and issues commands to the back part.
// ----------------------------------------------------------------------------
module dkh_front #(
	parameter int READ_MAX = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_mode,
	input  logic [7:0]                  in_char,
	input  logic                        in_last,
	input  logic [15:0]                 in_qidx,
	// buffer write port
	output logic                        buf_we,
	output logic [$clog2(READ_MAX)-1:0] buf_waddr,
	output logic [1:0]                  buf_wdata,
	// high while the back part reads the buffer
	input  logic                        walk_busy,
	// command out: query or end of read
	output logic                        cmd_valid,
	input  logic                        cmd_ready,
	output logic                        cmd_query,
	output logic                        cmd_used,
	output logic [$clog2(READ_MAX):0]   cmd_len,
	output logic [15:0]                 cmd_qidx
);
	import dkh_pkg::*;
	localparam int LW = $clog2(READ_MAX) + 1;

	logic [LW-1:0] len_q;
	logic          rvalid_q;
	logic          busy_q;
	base_dec_t     dec;
	logic          acc, full;

	assign dec = decode_base(in_char);
	assign full = (len_q == LW'(READ_MAX));
	// a finished read owns the buffer until the back part walks it
	assign in_ready = !busy_q && !walk_busy;
	assign acc = in_valid && in_ready;
	assign buf_we = acc && in_mode == MODE_BASE && !full && dec.ok;
	assign buf_waddr = len_q[LW-2:0];
	assign buf_wdata = dec.code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			rvalid_q <= 1'b1;
			busy_q <= 1'b0;
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				cmd_valid <= 1'b0;
				busy_q <= 1'b0;
			end
			if (acc) begin
				if (in_mode == MODE_QUERY) begin
					cmd_valid <= 1'b1;
					busy_q <= 1'b1;
					cmd_query <= 1'b1;
					cmd_qidx <= in_qidx;
				end else begin
					logic [LW-1:0] nl;
					logic          nv;
					nl = full ? len_q : len_q + 1'b1;
					nv = rvalid_q && !full && dec.ok;
					if (in_last) begin
						cmd_valid <= 1'b1;
						busy_q <= 1'b1;
						cmd_query <= 1'b0;
						cmd_used <= nv;
						cmd_len <= nl;
						len_q <= '0;
						rvalid_q <= 1'b1;
					end else begin
						len_q <= nl;
						rvalid_q <= nv;
					end
				end
			end
		end
	end
endmodule

### rtl/dkh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkh_back
// Clears the table, walks kept reads to update counts, answers queries and reports read verdicts.
// ----------------------------------------------------------------------------
module dkh_back #(
	parameter int KMER_MAX    = 8,
	parameter int READ_MAX    = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [3:0]                  kmer_length,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  logic                        cmd_query,
	input  logic                        cmd_used,
	input  logic [$clog2(READ_MAX):0]   cmd_len,
	input  logic [15:0]                 cmd_qidx,
	output logic [$clog2(READ_MAX)-1:0] buf_raddr,
	input  logic [1:0]                  buf_rdata,
	output logic                        walk_busy,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        out_kind,
	output logic                        out_used,
	output logic [31:0]                 out_count
);
	import dkh_pkg::*;
	localparam int TW = 2 * KMER_MAX;
	localparam int LW = $clog2(READ_MAX) + 1;
	localparam int KW = $clog2(KMER_MAX + 1);

	bk_state_t st_q, st_d;
	logic [TW-1:0] clr_q, code_q;
	logic [LW-1:0] pos_q, len_q;
	logic [KW-1:0] fill_q, k_eff;
	logic          tbl_we;
	logic [TW-1:0] tbl_waddr, tbl_raddr;
	logic [COUNT_WIDTH-1:0] tbl_wdata, tbl_rdata;
	logic [TW-1:0] code_nx;

	always_comb begin
		if (kmer_length == 4'd0) k_eff = KW'(1);
		else if (32'(kmer_length) > KMER_MAX) k_eff = KW'(KMER_MAX);
		else k_eff = KW'(kmer_length);
	end

	dkh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << TW)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
		.raddr(tbl_raddr), .rdata(tbl_rdata)
	);

	assign code_nx = TW'({code_q, buf_rdata})
		& TW'(({{TW{1'b0}}, 1'b1} << (2 * k_eff)) - 1'b1);
	// first buffer entry is fetched while idle
	assign buf_raddr = (st_q == BK_IDLE) ? '0 : pos_q[LW-2:0];
	assign walk_busy = (st_q == BK_WREAD) || (st_q == BK_WUPD);
	assign cmd_ready = (st_q == BK_IDLE) && !out_valid;

	always_comb begin
		st_d = st_q;
		tbl_we = 1'b0;
		tbl_waddr = code_q;
		tbl_wdata = tbl_rdata + 1'b1;
		tbl_raddr = code_nx;
		unique case (st_q)
			BK_CLEAR: begin
				tbl_we = 1'b1;
				tbl_waddr = clr_q;
				tbl_wdata = '0;
				if (&clr_q) st_d = BK_IDLE;
			end
			BK_IDLE: begin
				tbl_raddr = TW'(cmd_qidx);
				if (cmd_valid && cmd_ready) begin
					if (cmd_query) st_d = BK_QRD;
					else if (cmd_used && cmd_len != '0) st_d = BK_WREAD;
					else st_d = BK_OUT;
				end
			end
			BK_QRD: st_d = BK_OUT;
			// buffer data for pos_q is present this cycle
			BK_WREAD: st_d = BK_WUPD;
			BK_WUPD: begin
				// code_q complete: table data for it is on rdata
				if (fill_q == k_eff) tbl_we = !(&tbl_rdata);
				if (pos_q == len_q) st_d = BK_OUT;
				else st_d = BK_WREAD;
			end
			BK_OUT: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_CLEAR;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				BK_CLEAR: clr_q <= clr_q + 1'b1;
				BK_IDLE: if (cmd_valid && cmd_ready) begin
					out_kind <= cmd_query ? KIND_COUNT : KIND_VERDICT;
					out_used <= cmd_query ? 1'b0 : cmd_used;
					out_count <= '0;
					len_q <= cmd_len;
					pos_q <= '0;
					fill_q <= '0;
					code_q <= '0;
				end
				BK_QRD: out_count <= 32'(tbl_rdata);
				BK_WREAD: begin
					// consume buffer entry pos_q, read table at new window
					code_q <= code_nx;
					pos_q <= pos_q + 1'b1;
					if (fill_q != k_eff) fill_q <= fill_q + 1'b1;
				end
				BK_WUPD: if (st_d == BK_WREAD) begin
				end
				BK_OUT: out_valid <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

### rtl/dna_kmer_histogram_unit.sv
`timescale 1ns / 1ps
// bases stall while a kept read is walked or a query/end waits for the back part
// a query reads the table in BK_QRD and its result is sent from BK_OUT
// a kept read is walked base by base with a table read-modify-write each
// a verdict is sent from BK_OUT, after the walk if the read is kept, else directly
// after reset a clearing pass zeroes all 4^KMER_MAX table entries; queries/ends wait
// ----------------------------------------------------------------------------
// dna_kmer_histogram_unit
// K-mer histogram over DNA reads with count query.
// ----------------------------------------------------------------------------
module dna_kmer_histogram_unit #(
	parameter int KMER_MAX    = 8,
	parameter int READ_MAX    = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // base_char[7:0], query_index[23:8]
	input  logic        s_axis_tlast,  // end_of_read
	input  logic        s_axis_tuser,  // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // read_used[0], count_value[32:1], zero pad
	output logic        m_axis_tuser   // result_kind
);
	import dkh_pkg::*;
	localparam int LW = $clog2(READ_MAX) + 1;

	logic [3:0] k_q;
	logic buf_we;
	logic [LW-2:0] buf_waddr, buf_raddr;
	logic [1:0] buf_wdata, buf_rdata;
	logic walk_busy;
	logic cmd_valid, cmd_ready, cmd_query, cmd_used;
	logic [LW-1:0] cmd_len;
	logic [15:0] cmd_qidx;
	logic used;
	logic [31:0] cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= 4'd4;
		else if (cfg_we) k_q <= cfg_wdata;
	end

	dkh_front #(.READ_MAX(READ_MAX)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_mode(s_axis_tuser), .in_char(s_axis_tdata[7:0]), .in_last(s_axis_tlast),
		.in_qidx(s_axis_tdata[23:8]), .buf_we(buf_we), .buf_waddr(buf_waddr),
		.buf_wdata(buf_wdata), .walk_busy(walk_busy), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .cmd_query(cmd_query), .cmd_used(cmd_used),
		.cmd_len(cmd_len), .cmd_qidx(cmd_qidx)
	);

	dkh_ram #(.WIDTH(2), .DEPTH(READ_MAX)) u_buf (
		.clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
		.raddr(buf_raddr), .rdata(buf_rdata)
	);

	dkh_back #(.KMER_MAX(KMER_MAX), .READ_MAX(READ_MAX), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .kmer_length(k_q), .cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready), .cmd_query(cmd_query), .cmd_used(cmd_used),
		.cmd_len(cmd_len), .cmd_qidx(cmd_qidx), .buf_raddr(buf_raddr),
		.buf_rdata(buf_rdata), .walk_busy(walk_busy), .out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready), .out_kind(m_axis_tuser), .out_used(used),
		.out_count(cnt)
	);

	assign m_axis_tdata = {7'd0, cnt, used};
endmodule

### rtl/dkh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkh_checker
// Port-level checks of the k-mer histogram unit.
// ----------------------------------------------------------------------------
module dkh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	import dkh_pkg::*;

	// a waiting request is not withdrawn
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
		else $error("request withdrawn");
	// result stays up until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	// a verdict carries no count
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_VERDICT |-> m_axis_tdata[32:1] == '0)
		else $error("verdict with count");
	// a readout carries no used flag
	a_query: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_COUNT |-> !m_axis_tdata[0])
		else $error("readout with used flag");
	// pad bits are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:33] == '0)
		else $error("pad not zero");
endmodule

bind dna_kmer_histogram_unit dkh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

### tb/sv/dna_kmer_histogram_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_kmer_histogram_unit_test
// Streams DNA reads and count queries into the k-mer histogram unit. A local
// histogram predicts each verdict and each readout, and every result is
// compared field by field. The k-mer length setting changes between phases.
// ----------------------------------------------------------------------------
module dna_kmer_histogram_unit_test;
	import dkh_pkg::*;

	localparam int KMAX = 8;
	localparam int RMAX = 1024;
	localparam int TSIZE = 1 << (2 * KMAX);
	localparam int WATCH_LIMIT = 200000;

	typedef struct packed {
		logic        mode;
		logic [7:0]  ch;
		logic        last;
		logic [15:0] qidx;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic        used;
		logic [31:0] count;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	dna_kmer_histogram_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// local histogram model
	logic [31:0] hist [TSIZE];
	logic [1:0]  held_bases [RMAX];
	int          held_len;
	bit          held_ok;
	logic [3:0]  kmer_reg;

	request_t pending_reqs [$];
	outcome_t expected_results [$];
	int  mismatches, sent, received, idle_cycles;
	bit  tx_calm, rx_calm, rx_hold;

	function automatic int eff_k();
		if (kmer_reg < 1) return 1;
		if (kmer_reg > KMAX) return KMAX;
		return kmer_reg;
	endfunction

	task automatic predict_histogram(input request_t r);
		outcome_t o;
		int k, code;
		o = '0;
		if (r.mode == MODE_QUERY) begin
			o.kind = KIND_COUNT;
			o.count = hist[r.qidx];
			expected_results.push_back(o);
			return;
		end
		if (held_len >= RMAX) begin
			held_ok = 0;
		end else begin
			case (r.ch)
				CHAR_A: held_bases[held_len] = 2'd0;
				CHAR_C: held_bases[held_len] = 2'd1;
				CHAR_G: held_bases[held_len] = 2'd2;
				CHAR_T: held_bases[held_len] = 2'd3;
				default: held_ok = 0;
			endcase
			held_len++;
		end
		if (!r.last) return;
		o.kind = KIND_VERDICT;
		o.used = held_ok;
		if (held_ok) begin
			k = eff_k();
			for (int s = 0; s + k <= held_len; s++) begin
				code = 0;
				for (int j = 0; j < k; j++) code = (code << 2) | held_bases[s + j];
				if (hist[code] != 32'hFFFF_FFFF) hist[code]++;
			end
		end
		expected_results.push_back(o);
		held_len = 0;
		held_ok = 1;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 0;
			s_axis_tuser <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_histogram(pending_reqs.pop_front());
				sent++;
			end
			if ((!s_axis_tvalid || s_axis_tready) && pending_reqs.size() > 0
					&& (tx_calm || $urandom_range(99) >= 36)) begin
				s_axis_tvalid <= 1;
				s_axis_tdata <= {pending_reqs[0].qidx, pending_reqs[0].ch};
				s_axis_tlast <= pending_reqs[0].last;
				s_axis_tuser <= pending_reqs[0].mode;
			end else if (!s_axis_tvalid || s_axis_tready) begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.used = m_axis_tdata[0];
				got.count = m_axis_tdata[32:1];
				received++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: kind %b/%b used %b/%b count %0d/%0d",
								want.kind, got.kind, want.used, got.used,
								want.count, got.count);
					end
				end
			end
			m_axis_tready <= !rx_hold && (rx_calm || $urandom_range(99) >= 36);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rx_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] rand_base();
		case ($urandom_range(3))
			0: return CHAR_A;
			1: return CHAR_C;
			2: return CHAR_G;
			default: return CHAR_T;
		endcase
	endfunction

	task automatic add_read(input int len, input int bad_pct);
		request_t r;
		for (int i = 0; i < len; i++) begin
			r.mode = MODE_BASE;
			r.ch = ($urandom_range(99) < bad_pct) ? 8'($urandom) : rand_base();
			r.last = (i == len - 1);
			r.qidx = 16'($urandom);
			pending_reqs.push_back(r);
		end
	endtask

	task automatic add_query(input logic [15:0] q);
		request_t r;
		r.mode = MODE_QUERY;
		r.ch = 8'($urandom);
		r.last = 1'($urandom_range(1));
		r.qidx = q;
		pending_reqs.push_back(r);
	endtask

	task automatic drain_and_set(input logic [3:0] k);
		wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (20) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 0;
		kmer_reg = k;
	endtask

	task automatic random_phase(input int n);
		int made;
		made = 0;
		while (made < n) begin
			case ($urandom_range(9))
				0, 1: begin add_query(16'($urandom)); made++; end
				2: begin add_query(16'($urandom_range(255))); made++; end
				default: begin
					int len;
					len = ($urandom_range(19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
					add_read(len, ($urandom_range(4) == 0) ? 10 : 0);
					made += len;
				end
			endcase
		end
	endtask

	initial begin
		request_t r;
		cfg_we = 0; cfg_wdata = 0; arst_n = 0;
		mismatches = 0; sent = 0; received = 0; idle_cycles = 0;
		tx_calm = 0; rx_calm = 0; rx_hold = 0;
		for (int i = 0; i < TSIZE; i++) hist[i] = '0;
		held_len = 0; held_ok = 1; kmer_reg = 4;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, bad chars, short reads, index extremes
		add_query(16'h0000);
		add_query(16'hFFFF);
		r = '0; r.ch = CHAR_A; r.last = 1; pending_reqs.push_back(r);
		r.ch = 8'hFF; pending_reqs.push_back(r);
		r.ch = 8'h00; pending_reqs.push_back(r);
		r.ch = CHAR_T; r.last = 0; r.qidx = 16'hFFFF;
		repeat (4) pending_reqs.push_back(r);
		r.ch = CHAR_G; r.last = 1; pending_reqs.push_back(r);
		r.ch = 8'h61; r.last = 0; pending_reqs.push_back(r);
		add_query(16'hFFFF);
		r.ch = CHAR_C; r.last = 1; pending_reqs.push_back(r);
		add_query(16'h00FF);
		add_query(16'h00FE);
		drain_and_set(4'd0);
		add_read(3, 0);
		add_query(16'h0000);
		drain_and_set(4'd15);

		// overflowing read, then a query
		add_read(RMAX + 1, 0);
		add_query(16'($urandom));
		drain_and_set(4'd8);
		random_phase(30);
		drain_and_set(4'd1);
		random_phase(30);

		// receiver holds off while the sender keeps offering
		rx_hold = 1;
		tx_calm = 1;
		random_phase(40);
		repeat (400) @(posedge clk);
		rx_hold = 0;
		tx_calm = 0;
		drain_and_set(4'd2);
		random_phase(30);
		drain_and_set(4'd5);
		rx_calm = 1; tx_calm = 1;
		random_phase(20);
		drain_and_set(4'd4);
		rx_calm = 0; tx_calm = 0;
		random_phase(20);
		wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (50) @(posedge clk);
		$display("sent %0d requests and checked %0d results over k-mer lengths 0..15",
			sent, received);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

### files.f
rtl/dkh_pkg.sv
rtl/dkh_ram.sv
rtl/dkh_front.sv
rtl/dkh_back.sv
rtl/dna_kmer_histogram_unit.sv
rtl/dkh_checker.sv
tb/sv/dna_kmer_histogram_unit_test.sv
